@@ sv/lpht_pkg.sv @@
// Package with shared types and constants for the linear probing hash table.
`timescale 1ns / 1ps
package lpht_pkg;
  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_TOMB  = 2'd2
  } mark_t;

  typedef enum logic [2:0] {
    ST_FOUND    = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_INSERTED = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_SET    = 2'd1,
    OP_REMOVE = 2'd2
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_HASH, S_READ, S_CHECK, S_WRITE, S_DONE
  } state_t;

  // The home slot is taken from the low hash bits, so the table size stays a
  // power of two.
  localparam int SLOTS = 4096;

  localparam logic [63:0] MIX_A = 64'h5555555555555555;
  localparam logic [63:0] MIX_B = 64'd17316035218449499591;
  localparam logic [11:0] FILL_RESET = 12'd3276;
endpackage

@@ sv/lpht_mixer.sv @@
// Key hash: two xor-shift-multiply rounds on one 32x32 multiplier over cycles.
`timescale 1ns / 1ps
module lpht_mixer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] key,
  output logic        done,
  output logic [63:0] hash
);
  // Each round: x ^= x>>32, then x*M mod 2^64 from three 32x32 products.
  logic [63:0] x_r, x_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [2:0]  step_r, step_nxt;
  logic        round_r, round_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [31:0] ma, mb;
  logic [63:0] prod;
  logic [63:0] mconst;

  assign mconst = round_r ? lpht_pkg::MIX_B : lpht_pkg::MIX_A;

  always_comb begin
    case (step_r)
      3'd0: begin ma = x_r[31:0];  mb = mconst[31:0];  end
      3'd1: begin ma = x_r[63:32]; mb = mconst[31:0];  end
      default: begin ma = x_r[31:0]; mb = mconst[63:32]; end
    endcase
  end

  assign prod = {32'd0, ma} * {32'd0, mb};

  always_comb begin
    x_nxt = x_r;
    acc_nxt = acc_r;
    step_nxt = step_r;
    round_nxt = round_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt = key ^ {32'd0, key[63:32]};
      acc_nxt = '0;
      step_nxt = '0;
      round_nxt = 1'b0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      case (step_r)
        3'd0: begin acc_nxt = prod; step_nxt = 3'd1; end
        3'd1: begin acc_nxt = acc_r + {prod[31:0], 32'd0}; step_nxt = 3'd2; end
        default: begin
          if (round_r) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
            x_nxt = acc_r + {prod[31:0], 32'd0};
          end else begin
            x_nxt = (acc_r + {prod[31:0], 32'd0})
                  ^ {32'd0, acc_r[63:32] + prod[31:0]};
            round_nxt = 1'b1;
          end
          step_nxt = 3'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    acc_r <= acc_nxt;
    step_r <= step_nxt;
    round_r <= round_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign hash = x_r;
endmodule

@@ sv/linear_probe_hash_table.sv @@
// Top level of the linear probing hash table with its slot memories and sequencer.
`timescale 1ns / 1ps
// Each request hashes the key (one 32x32 multiplier used six times), then
// reads and checks each probed slot through the registered slot memory read
// port, then passes a write state and a state that loads the result register.
// The result word waits in an output register, and the next request word is
// taken only in the cycle after the result is taken, so one request is handled
// at a time. After reset a clearing pass marks every slot empty, during which
// no request word is accepted.
module linear_probe_hash_table #(
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [63:0] in_key,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_value_out,
  output logic [11:0] out_slot_index,
  output logic [11:0] out_live_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_fill_limit
);
  localparam int AW = $clog2(lpht_pkg::SLOTS);
  localparam int SW = AW + 1;
  localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;

  logic [63:0]         key_mem [lpht_pkg::SLOTS];
  logic [VALUE_BITS-1:0] val_mem [lpht_pkg::SLOTS];
  logic [1:0]          mark_mem [lpht_pkg::SLOTS];

  lpht_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt, home_r, home_nxt;
  logic [SW-1:0] steps_r, steps_nxt;
  logic [1:0]    op_r;
  logic [63:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [11:0]   count_r, count_nxt, fill_r;
  logic [63:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic [1:0]    rd_mark;
  logic          res_r, res_nxt;  // found
  logic          hit_empty_r, hit_empty_nxt;
  logic          ov_r, ov_nxt;
  logic [2:0]    st_r, st_nxt;
  logic [31:0]   vo_r, vo_nxt;
  logic [AW-1:0] so_r, so_nxt;
  logic          we;
  logic [1:0]    we_mark;
  logic          we_kv;
  logic [AW-1:0] we_addr;
  logic          mix_done;
  logic [63:0]   mix_hash;
  logic          accept;

  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == lpht_pkg::S_IDLE) && !ov_r;
  assign cfg_ready = 1'b1;

  lpht_mixer u_mix (
    .clk(clk), .rst_n(rst_n), .start(accept), .key(in_key),
    .done(mix_done), .hash(mix_hash)
  );

  always_ff @(posedge clk) begin
    rd_key <= key_mem[idx_r];
    rd_val <= val_mem[idx_r];
    rd_mark <= mark_mem[idx_r];
    if (we) begin
      mark_mem[we_addr] <= we_mark;
      if (we_kv) key_mem[we_addr] <= key_r;
    end
    if (we && (we_kv || op_r == lpht_pkg::OP_SET)) val_mem[we_addr] <= val_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpht_pkg::S_CLEAR: if (idx_r == AW'(lpht_pkg::SLOTS - 1)) state_nxt = lpht_pkg::S_IDLE;
      lpht_pkg::S_IDLE:  if (accept) state_nxt = lpht_pkg::S_HASH;
      lpht_pkg::S_HASH:  if (mix_done) state_nxt = lpht_pkg::S_READ;
      lpht_pkg::S_READ:  state_nxt = lpht_pkg::S_CHECK;
      lpht_pkg::S_CHECK: begin
        if ((rd_mark == lpht_pkg::MARK_EMPTY) ||
            (rd_mark == lpht_pkg::MARK_LIVE && rd_key == key_r) ||
            (steps_r == SW'(lpht_pkg::SLOTS - 1)))
          state_nxt = lpht_pkg::S_WRITE;
        else
          state_nxt = lpht_pkg::S_READ;
      end
      lpht_pkg::S_WRITE: state_nxt = lpht_pkg::S_DONE;
      lpht_pkg::S_DONE:  state_nxt = lpht_pkg::S_IDLE;
      default:           state_nxt = lpht_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    home_nxt = home_r;
    steps_nxt = steps_r;
    res_nxt = res_r;
    hit_empty_nxt = hit_empty_r;
    count_nxt = count_r;
    ov_nxt = ov_r;
    st_nxt = st_r;
    vo_nxt = vo_r;
    so_nxt = so_r;
    we = 1'b0;
    we_kv = 1'b0;
    we_mark = lpht_pkg::MARK_EMPTY;
    we_addr = idx_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      lpht_pkg::S_CLEAR: begin
        we = 1'b1;
        idx_nxt = idx_r + AW'(1);
      end
      lpht_pkg::S_HASH: if (mix_done) begin
        idx_nxt = mix_hash[AW-1:0];
        home_nxt = mix_hash[AW-1:0];
        steps_nxt = '0;
      end
      lpht_pkg::S_CHECK: begin
        res_nxt = (rd_mark == lpht_pkg::MARK_LIVE) && (rd_key == key_r);
        hit_empty_nxt = (rd_mark == lpht_pkg::MARK_EMPTY);
        vo_nxt = 32'(rd_val[VW-1:0]);
        if (state_nxt == lpht_pkg::S_READ) begin
          idx_nxt = idx_r + AW'(1);
          steps_nxt = steps_r + SW'(1);
        end else if (!(rd_mark == lpht_pkg::MARK_EMPTY) &&
                     !(rd_mark == lpht_pkg::MARK_LIVE && rd_key == key_r)) begin
          idx_nxt = home_r;
        end
      end
      lpht_pkg::S_WRITE: begin
        so_nxt = 12'(idx_r);
        // Opcode three is a lookup too and returns the stored value.
        if (op_r == lpht_pkg::OP_SET || op_r == lpht_pkg::OP_REMOVE || !res_r)
          vo_nxt = '0;
        case (op_r)
          lpht_pkg::OP_SET: begin
            if (res_r) begin
              we = 1'b1; we_mark = lpht_pkg::MARK_LIVE;
              st_nxt = lpht_pkg::ST_UPDATED;
            end else if (hit_empty_r && count_r < fill_r) begin
              we = 1'b1; we_kv = 1'b1; we_mark = lpht_pkg::MARK_LIVE;
              count_nxt = count_r + 12'd1;
              st_nxt = lpht_pkg::ST_INSERTED;
            end else st_nxt = lpht_pkg::ST_FULL;
          end
          lpht_pkg::OP_REMOVE: begin
            if (res_r) begin
              we = 1'b1; we_mark = lpht_pkg::MARK_TOMB;
              if (count_r != 12'd0) count_nxt = count_r - 12'd1;
              st_nxt = lpht_pkg::ST_REMOVED;
            end else st_nxt = lpht_pkg::ST_NOTFOUND;
          end
          default: st_nxt = res_r ? lpht_pkg::ST_FOUND : lpht_pkg::ST_NOTFOUND;
        endcase
      end
      lpht_pkg::S_DONE: ov_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_opcode;
      key_r <= in_key;
      val_r <= VALUE_BITS'(in_value);
    end
    home_r <= home_nxt;
    steps_r <= steps_nxt;
    res_r <= res_nxt;
    hit_empty_r <= hit_empty_nxt;
    st_r <= st_nxt;
    vo_r <= vo_nxt;
    so_r <= so_nxt;
    if (!rst_n) begin
      state_r <= lpht_pkg::S_CLEAR;
      idx_r <= '0;
      count_r <= '0;
      fill_r <= lpht_pkg::FILL_RESET;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      count_r <= count_nxt;
      ov_r <= ov_nxt;
      if (cfg_valid && cfg_ready) fill_r <= cfg_fill_limit;
    end
  end

  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_value_out = vo_r;
  assign out_slot_index = so_r;
  assign out_live_count = count_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != lpht_pkg::S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && st_r == lpht_pkg::ST_INSERTED && $rose(ov_r)) |-> (count_r != 12'd0))
    else $error("insert left count zero");
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lpht_pkg::S_WRITE && count_nxt != count_r &&
     op_r == lpht_pkg::OP_SET) |-> (count_r < fill_r)) else $error("fill limit passed");
endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the linear probing hash table.
`timescale 1ns / 1ps
module tb_top;
  localparam int NSLOT = 4096;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    lpht_pkg::opcode_t op;
    logic [63:0] key;
    logic [31:0] value;
  } request_t;

  typedef struct {
    lpht_pkg::status_t status;
    logic [31:0] value_out;
    logic [11:0] slot;
    logic [11:0] live;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode = '0;
  logic [63:0] in_key = '0;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_value_out;
  logic [11:0] out_slot_index;
  logic [11:0] out_live_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [11:0] cfg_fill_limit = '0;

  linear_probe_hash_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_key(in_key), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_value_out(out_value_out), .out_slot_index(out_slot_index),
    .out_live_count(out_live_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_fill_limit(cfg_fill_limit)
  );

  // Shadow copy of the table.
  logic [63:0] shadow_key[NSLOT];
  logic [31:0] shadow_val[NSLOT];
  lpht_pkg::mark_t shadow_mark[NSLOT];
  int          shadow_count = 0;
  logic [11:0] shadow_limit = lpht_pkg::FILL_RESET;

  request_t pending_reqs[$];
  reply_t   expected_replies[$];
  logic [63:0] key_pool[$];

  int  errors = 0;
  int  cycles = 0;
  int  accepted = 0;
  int  status_seen[6];
  bit  in_taken = 0;
  bit  burst_mode = 0;
  int  send_gap = 0;
  int  recv_stall = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] mix_key(input logic [63:0] k);
    logic [63:0] h;
    h = lpht_pkg::MIX_A * (k ^ (k >> 32));
    return lpht_pkg::MIX_B * (h ^ (h >> 32));
  endfunction

  function automatic reply_t apply_request(input request_t rq);
    reply_t rp;
    int idx, home, where, found;
    home = int'(mix_key(rq.key) % NSLOT);
    idx = home;
    where = home;
    found = 0;
    for (int s = 0; s < NSLOT; s++) begin
      if (shadow_mark[idx] == lpht_pkg::MARK_EMPTY) begin
        where = idx;
        found = 2;
        break;
      end
      if (shadow_mark[idx] == lpht_pkg::MARK_LIVE && shadow_key[idx] == rq.key) begin
        where = idx;
        found = 1;
        break;
      end
      idx = (idx + 1) % NSLOT;
    end
    rp.value_out = '0;
    if (rq.op == lpht_pkg::OP_SET) begin
      if (found == 1) begin
        shadow_val[where] = rq.value;
        rp.status = lpht_pkg::ST_UPDATED;
      end else if (found == 2 && shadow_count < shadow_limit) begin
        shadow_key[where] = rq.key;
        shadow_val[where] = rq.value;
        shadow_mark[where] = lpht_pkg::MARK_LIVE;
        shadow_count++;
        rp.status = lpht_pkg::ST_INSERTED;
      end else begin
        rp.status = lpht_pkg::ST_FULL;
      end
    end else if (rq.op == lpht_pkg::OP_REMOVE) begin
      if (found == 1) begin
        shadow_mark[where] = lpht_pkg::MARK_TOMB;
        if (shadow_count > 0) shadow_count--;
        rp.status = lpht_pkg::ST_REMOVED;
      end else begin
        rp.status = lpht_pkg::ST_NOTFOUND;
      end
    end else begin
      // Opcode three behaves as a lookup.
      if (found == 1) begin
        rp.value_out = shadow_val[where];
        rp.status = lpht_pkg::ST_FOUND;
      end else begin
        rp.status = lpht_pkg::ST_NOTFOUND;
      end
    end
    rp.slot = where[11:0];
    rp.live = shadow_count[11:0];
    return rp;
  endfunction

  // Predict on accepted requests, check accepted results.
  always @(posedge clk) begin
    request_t rq;
    reply_t   rp;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout at %0t with %0d results outstanding", $time, expected_replies.size());
      $display("Some tests failed");
      $finish;
    end else begin
      in_taken = rst_n && in_valid && in_ready;
      if (in_taken) begin
        rq.op = lpht_pkg::opcode_t'(in_opcode);
        rq.key = in_key;
        rq.value = in_value;
        expected_replies.push_back(apply_request(rq));
        accepted++;
      end
      if (rst_n && out_valid && out_ready) begin
        recv_stall = burst_mode ? 0 : $urandom_range(0, 15);
        if (expected_replies.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, status %0d", $time, out_status);
        end else begin
          rp = expected_replies.pop_front();
          if (out_status < 6) status_seen[out_status]++;
          if (out_status !== rp.status || out_value_out !== rp.value_out ||
              out_slot_index !== rp.slot || out_live_count !== rp.live) begin
            errors++;
            $display("%0t: mismatch expected st=%0d val=%h slot=%0d live=%0d",
                     $time, rp.status, rp.value_out, rp.slot, rp.live);
            $display("%0t:          actual   st=%0d val=%h slot=%0d live=%0d",
                     $time, out_status, out_value_out, out_slot_index, out_live_count);
          end
        end
      end
    end
  end

  // Request driver.
  always @(negedge clk) begin
    request_t rq;
    if (rst_n && !(in_valid && !in_taken)) begin
      if (in_valid) send_gap = burst_mode ? 0 : $urandom_range(0, 15);
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        rq = pending_reqs.pop_front();
        in_opcode <= rq.op;
        in_key <= rq.key;
        in_value <= rq.value;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver stalls.
  always @(negedge clk) begin
    if (rst_n) begin
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_req(input logic [1:0] op, input logic [63:0] k, input logic [31:0] v);
    request_t rq;
    rq.op = lpht_pkg::opcode_t'(op);
    rq.key = k;
    rq.value = v;
    pending_reqs.push_back(rq);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_replies.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(input logic [11:0] lim);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_fill_limit <= lim;
    do @(posedge clk); while (!cfg_ready);
    shadow_limit = lim;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_reqs(input int n);
    logic [63:0] k;
    int pick;
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      k = {$urandom, $urandom};
      if ($urandom_range(0, 9) < 7) k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      else key_pool.push_back(k);
      pick = $urandom_range(0, 99);
      push_req(pick < 45 ? lpht_pkg::OP_SET : pick < 75 ? lpht_pkg::OP_LOOKUP :
               pick < 95 ? lpht_pkg::OP_REMOVE : 2'd3,
               k, $urandom);
    end
  endtask

  initial begin
    logic [63:0] k0, kc;
    for (int i = 0; i < NSLOT; i++) shadow_mark[i] = lpht_pkg::MARK_EMPTY;
    for (int i = 0; i < 300; i++) key_pool.push_back({$urandom, $urandom});
    // Find a second key that lands on the same home slot as the first.
    k0 = key_pool[0];
    do kc = {$urandom, $urandom};
    while (mix_key(kc) % NSLOT != mix_key(k0) % NSLOT);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    write_limit(lpht_pkg::FILL_RESET);
    push_req(lpht_pkg::OP_LOOKUP, 64'd0, 32'd0);
    push_req(lpht_pkg::OP_REMOVE, 64'd0, 32'd0);
    push_req(lpht_pkg::OP_SET, 64'd0, 32'hFFFF_FFFF);
    push_req(lpht_pkg::OP_SET, '1, 32'd0);
    push_req(lpht_pkg::OP_SET, '1, 32'h1234_5678);
    push_req(lpht_pkg::OP_LOOKUP, 64'd0, 32'd7);
    push_req(2'd3, '1, 32'd0);
    push_req(lpht_pkg::OP_SET, k0, 32'hA5A5_0001);
    push_req(lpht_pkg::OP_SET, kc, 32'h5A5A_0002);
    push_req(lpht_pkg::OP_REMOVE, k0, 32'd0);
    push_req(lpht_pkg::OP_LOOKUP, kc, 32'd0);
    push_req(lpht_pkg::OP_LOOKUP, k0, 32'd0);
    push_req(lpht_pkg::OP_SET, k0, 32'h0000_0003);
    push_req(lpht_pkg::OP_REMOVE, 64'd0, 32'd0);
    push_req(lpht_pkg::OP_LOOKUP, 64'd0, 32'd0);
    push_req(lpht_pkg::OP_SET, 64'd0, 32'd9);
    drain();

    // Limit of one: new keys are refused, updates still go through.
    write_limit(12'd1);
    push_req(lpht_pkg::OP_SET, 64'h0123_4567_89AB_CDEF, 32'd1);
    push_req(lpht_pkg::OP_SET, '1, 32'hCAFE_0000);
    random_reqs(20);
    drain();

    write_limit(12'd0);
    push_req(lpht_pkg::OP_SET, 64'h0000_0000_DEAD_BEEF, 32'd2);
    push_req(lpht_pkg::OP_SET, 64'd0, 32'd3);
    random_reqs(20);
    drain();

    write_limit(12'd4095);
    random_reqs(900);
    drain();

    write_limit(12'($urandom_range(20, 120)));
    random_reqs(600);
    drain();

    write_limit(12'($urandom_range(1, 4095)));
    random_reqs(400);
    drain();
    repeat (100) @(posedge clk);

    $display("Ran %0d requests across several fill limits: %0d found, %0d updated,",
             accepted, status_seen[0], status_seen[1]);
    $display("%0d inserted, %0d removed, %0d not found, %0d full.",
             status_seen[2], status_seen[3], status_seen[4], status_seen[5]);
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
sv/lpht_pkg.sv
sv/lpht_mixer.sv
sv/linear_probe_hash_table.sv
tb/tb_top.sv
